[design/matrix3x3_inverse_defines.svh]
// ----------------------------------------------------------------------------
// matrix3x3_inverse_defines
// assertion macros used by the matrix inverse top-level design file
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH
`ifndef ASSERT_OFF
// checked outside reset
`define MX3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define MX3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MX3_ASSERT(lbl, prop, msg)
`define MX3_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[design/mx3_pkg.sv]
// ----------------------------------------------------------------------------
// mx3_pkg
// types and constants of the 3x3 matrix inverse pipeline
// ----------------------------------------------------------------------------
`default_nettype none
package mx3_pkg;

  localparam int ENT_W         = 32;
  localparam int PROD_W        = 2 * ENT_W;
  localparam int ADJ_W         = PROD_W + 1;
  localparam int MAG_W         = PROD_W;
  localparam int DET_W         = 98;
  localparam int DEN_W         = 96;
  localparam int QBITS         = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int LANE_LAT      = QBITS + 2;
  localparam int PIPE_LAT      = 6 + LANE_LAT;

  typedef logic signed [ENT_W-1:0] ent_t;
  typedef logic signed [ADJ_W-1:0] adj_t;
  typedef logic signed [DET_W-1:0] det_t;

  typedef struct packed {
    logic signed [31:0] a00;
    logic signed [31:0] a01;
    logic signed [31:0] a02;
    logic signed [31:0] a10;
    logic signed [31:0] a11;
    logic signed [31:0] a12;
    logic signed [31:0] a20;
    logic signed [31:0] a21;
    logic signed [31:0] a22;
  } in_t;

  typedef struct packed {
    logic signed [31:0] r00;
    logic signed [31:0] r01;
    logic signed [31:0] r02;
    logic signed [31:0] r10;
    logic signed [31:0] r11;
    logic signed [31:0] r12;
    logic signed [31:0] r20;
    logic signed [31:0] r21;
    logic signed [31:0] r22;
    logic               singular;
    logic               saturated;
  } out_t;

endpackage
`default_nettype wire

[design/mx3_cofactor.sv]
// ----------------------------------------------------------------------------
// mx3_cofactor
// two stages: 2x2 minor products, then their differences as the adjugate
// ----------------------------------------------------------------------------
`default_nettype none
module mx3_cofactor (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire mx3_pkg::in_t  din,
  output mx3_pkg::adj_t      adj  [9],
  output mx3_pkg::ent_t      row0 [3]
);

  mx3_pkg::ent_t m [9];
  logic signed [mx3_pkg::PROD_W-1:0] p_nxt [18];
  logic signed [mx3_pkg::PROD_W-1:0] p_r   [18];
  mx3_pkg::ent_t row0_1_r [3];
  mx3_pkg::ent_t row0_2_r [3];
  mx3_pkg::adj_t adj_r [9];

  assign m[0] = din.a00;
  assign m[1] = din.a01;
  assign m[2] = din.a02;
  assign m[3] = din.a10;
  assign m[4] = din.a11;
  assign m[5] = din.a12;
  assign m[6] = din.a20;
  assign m[7] = din.a21;
  assign m[8] = din.a22;

  always_comb begin
    p_nxt[0]  = m[4] * m[8];
    p_nxt[1]  = m[5] * m[7];
    p_nxt[2]  = m[2] * m[7];
    p_nxt[3]  = m[1] * m[8];
    p_nxt[4]  = m[1] * m[5];
    p_nxt[5]  = m[2] * m[4];
    p_nxt[6]  = m[5] * m[6];
    p_nxt[7]  = m[3] * m[8];
    p_nxt[8]  = m[0] * m[8];
    p_nxt[9]  = m[2] * m[6];
    p_nxt[10] = m[2] * m[3];
    p_nxt[11] = m[0] * m[5];
    p_nxt[12] = m[3] * m[7];
    p_nxt[13] = m[4] * m[6];
    p_nxt[14] = m[1] * m[6];
    p_nxt[15] = m[0] * m[7];
    p_nxt[16] = m[0] * m[4];
    p_nxt[17] = m[1] * m[3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 18; i++) p_r[i] <= p_nxt[i];
      for (int i = 0; i < 3; i++) row0_1_r[i] <= m[i];
      for (int i = 0; i < 9; i++) begin
        adj_r[i] <= mx3_pkg::adj_t'(p_r[2*i]) - mx3_pkg::adj_t'(p_r[2*i+1]);
      end
      for (int i = 0; i < 3; i++) row0_2_r[i] <= row0_1_r[i];
    end
  end

  assign adj  = adj_r;
  assign row0 = row0_2_r;

endmodule
`default_nettype wire

[design/mx3_det.sv]
// ----------------------------------------------------------------------------
// mx3_det
// three stages: split partial products, recombine, sum along row 0
// ----------------------------------------------------------------------------
`default_nettype none
module mx3_det (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire mx3_pkg::adj_t adj_i [9],
  input  wire mx3_pkg::ent_t row0  [3],
  output mx3_pkg::adj_t      adj_o [9],
  output mx3_pkg::det_t      det
);

  localparam int PP_W = mx3_pkg::ADJ_W;

  logic signed [PP_W-1:0] plo_nxt [3];
  logic signed [PP_W-1:0] phi_nxt [3];
  logic signed [PP_W-1:0] plo_r   [3];
  logic signed [PP_W-1:0] phi_r   [3];
  mx3_pkg::det_t prod_r [3];
  mx3_pkg::det_t det_r;
  mx3_pkg::adj_t adj3_r [9];
  mx3_pkg::adj_t adj4_r [9];
  mx3_pkg::adj_t adj5_r [9];

  // row 0 weights the first column of the adjugate
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      plo_nxt[j] = row0[j] * $signed({1'b0, adj_i[3*j][31:0]});
      phi_nxt[j] = row0[j] * $signed(adj_i[3*j][PP_W-1:32]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        plo_r[j]  <= plo_nxt[j];
        phi_r[j]  <= phi_nxt[j];
        prod_r[j] <= $signed({phi_r[j][PP_W-1], phi_r[j], 32'd0})
                   + $signed({{(mx3_pkg::DET_W-PP_W){plo_r[j][PP_W-1]}}, plo_r[j]});
      end
      det_r <= prod_r[0] + prod_r[1] + prod_r[2];
      for (int i = 0; i < 9; i++) begin
        adj3_r[i] <= adj_i[i];
        adj4_r[i] <= adj3_r[i];
        adj5_r[i] <= adj4_r[i];
      end
    end
  end

  assign adj_o = adj5_r;
  assign det   = det_r;

endmodule
`default_nettype wire

[design/mx3_div_lane.sv]
// ----------------------------------------------------------------------------
// mx3_div_lane
// one inverse entry: scaling, range check, radix-2 restoring division
// with one quotient bit per stage, then signed saturation
// ----------------------------------------------------------------------------
`default_nettype none
module mx3_div_lane #(
  parameter int FRAC_BITS = mx3_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [mx3_pkg::MAG_W-1:0]   mag,
  input  wire logic                        neg,
  input  wire logic [mx3_pkg::DEN_W-1:0]   den,
  output mx3_pkg::ent_t                    val,
  output logic                             sat
);

  localparam int QB    = mx3_pkg::QBITS;
  localparam int DW    = mx3_pkg::DEN_W;
  localparam int NUM_W = mx3_pkg::MAG_W + 2 * FRAC_BITS;
  localparam int HI_W  = NUM_W - QB;

  logic [NUM_W-1:0] num;
  logic [DW-1:0]    hi_ext;

  logic [DW-1:0] rem_r [QB+1];
  logic [QB-1:0] lo_r  [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic [DW-1:0] den_r [QB+1];
  logic          ovf_r [QB+1];
  logic          neg_r [QB+1];

  mx3_pkg::ent_t val_r;
  logic          sat_r;
  mx3_pkg::ent_t val_nxt;
  logic          sat_nxt;

  assign num    = {mag, {(2*FRAC_BITS){1'b0}}};
  assign hi_ext = {{(DW-HI_W){1'b0}}, num[NUM_W-1:QB]};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_ext;
      lo_r[0]  <= num[QB-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den;
      ovf_r[0] <= (hi_ext >= den);
      neg_r[0] <= neg;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DW:0] trial;
    logic        take;
    logic [DW:0] diff;
    assign trial = {rem_r[k], lo_r[k][QB-1]};
    assign take  = (trial >= {1'b0, den_r[k]});
    assign diff  = trial - {1'b0, den_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? diff[DW-1:0] : trial[DW-1:0];
        lo_r[k+1]  <= {lo_r[k][QB-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][QB-2:0], take};
        den_r[k+1] <= den_r[k];
        ovf_r[k+1] <= ovf_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  always_comb begin
    if (neg_r[QB]) begin
      if (ovf_r[QB] || (q_r[QB] > {1'b1, {(QB-1){1'b0}}})) begin
        val_nxt = $signed({1'b1, {(QB-1){1'b0}}});
        sat_nxt = 1'b1;
      end else begin
        val_nxt = $signed(-q_r[QB]);
        sat_nxt = 1'b0;
      end
    end else begin
      if (ovf_r[QB] || q_r[QB][QB-1]) begin
        val_nxt = $signed({1'b0, {(QB-1){1'b1}}});
        sat_nxt = 1'b1;
      end else begin
        val_nxt = $signed(q_r[QB]);
        sat_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign val = val_r;
  assign sat = sat_r;

endmodule
`default_nettype wire

[design/matrix3x3_inverse.sv]
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 inverse by adjugate over determinant, signed fixed point, pipelined
//
//   channel  ports                       carries
//   in       in_valid in_ready in_data   one matrix, nine entries
//   out      out_valid out_ready out_data nine inverse entries, flags
//
// one matrix accepted per cycle while the output is not stalled
// each lane is a chain of 32 one-bit restoring division stages
// a stalled output freezes every stage at once, no item lost or repeated
// reset clears the valid bits only
// ----------------------------------------------------------------------------
`default_nettype none
`include "matrix3x3_inverse_defines.svh"
module matrix3x3_inverse #(
  parameter int FRAC_BITS = mx3_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mx3_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mx3_pkg::out_t      out_data
);

  localparam int LAT = mx3_pkg::PIPE_LAT;
  localparam int LL  = mx3_pkg::LANE_LAT;

  logic en;
  logic v_r [LAT];

  mx3_pkg::adj_t adj2 [9];
  mx3_pkg::ent_t row0 [3];
  mx3_pkg::adj_t adj5 [9];
  mx3_pkg::det_t det5;

  logic [mx3_pkg::MAG_W-1:0] mag_r [9];
  logic                      neg_r [9];
  logic [mx3_pkg::DEN_W-1:0] den_r;
  logic                      zp_r [LL+1];

  mx3_pkg::det_t det_abs;
  mx3_pkg::adj_t adj_abs [9];

  mx3_pkg::ent_t val [9];
  logic          sat [9];
  logic          any_sat;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) v_r[i] <= v_r[i-1];
    end
  end

  mx3_cofactor u_cof (
    .clk  (clk),
    .en   (en),
    .din  (in_data),
    .adj  (adj2),
    .row0 (row0)
  );

  mx3_det u_det (
    .clk   (clk),
    .en    (en),
    .adj_i (adj2),
    .row0  (row0),
    .adj_o (adj5),
    .det   (det5)
  );

  // magnitudes and quotient signs
  always_comb begin
    det_abs = det5[mx3_pkg::DET_W-1] ? -det5 : det5;
    for (int i = 0; i < 9; i++) adj_abs[i] = adj5[i][mx3_pkg::ADJ_W-1] ? -adj5[i] : adj5[i];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r    <= det_abs[mx3_pkg::DEN_W-1:0];
      zp_r[0]  <= (det5 == '0);
      for (int i = 0; i < 9; i++) begin
        mag_r[i] <= adj_abs[i][mx3_pkg::MAG_W-1:0];
        neg_r[i] <= adj5[i][mx3_pkg::ADJ_W-1] ^ det5[mx3_pkg::DET_W-1];
      end
      for (int i = 1; i <= LL; i++) zp_r[i] <= zp_r[i-1];
    end
  end

  for (genvar i = 0; i < 9; i++) begin : g_lane
    mx3_div_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .en  (en),
      .mag (mag_r[i]),
      .neg (neg_r[i]),
      .den (den_r),
      .val (val[i]),
      .sat (sat[i])
    );
  end

  always_comb begin
    any_sat = 1'b0;
    for (int i = 0; i < 9; i++) any_sat = any_sat | sat[i];
    if (zp_r[LL]) begin
      out_data = '0;
      out_data.singular = 1'b1;
    end else begin
      out_data.r00       = val[0];
      out_data.r01       = val[1];
      out_data.r02       = val[2];
      out_data.r10       = val[3];
      out_data.r11       = val[4];
      out_data.r12       = val[5];
      out_data.r20       = val[6];
      out_data.r21       = val[7];
      out_data.r22       = val[8];
      out_data.singular  = 1'b0;
      out_data.saturated = any_sat;
    end
  end

  assign out_valid = v_r[LAT-1];

  `MX3_ASSERT_ALWAYS(a_rst_clears, !rst_n |=> !out_valid, "valid left after reset")
  `MX3_ASSERT(a_sing_no_sat, out_valid && out_data.singular |-> !out_data.saturated, "singular with saturation")
  `MX3_ASSERT(a_sing_zero, out_valid && out_data.singular |-> out_data.r00 == 0 && out_data.r22 == 0, "singular entries nonzero")

endmodule
`default_nettype wire

[tb/mx3_inverse_checker.sv]
// ----------------------------------------------------------------------------
// mx3_inverse_checker
// watches both channels of the 3x3 inverse, predicts each result from the
// accepted matrix and compares the whole result with what comes out
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module mx3_inverse_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  mx3_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  mx3_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);

  mx3_pkg::out_t inverse_q[$];

  function automatic logic signed [127:0] cross_term(
    logic signed [127:0] p, logic signed [127:0] q,
    logic signed [127:0] r, logic signed [127:0] s);
    return p * q - r * s;
  endfunction

  function automatic mx3_pkg::out_t predict_inverse(mx3_pkg::in_t a);
    logic signed [127:0] m [9];
    logic signed [127:0] adj [9];
    logic signed [127:0] det;
    logic [127:0] det_mag, num, quo;
    logic [31:0] ent [9];
    logic neg, sat;
    mx3_pkg::out_t res;
    m[0] = a.a00; m[1] = a.a01; m[2] = a.a02;
    m[3] = a.a10; m[4] = a.a11; m[5] = a.a12;
    m[6] = a.a20; m[7] = a.a21; m[8] = a.a22;
    adj[0] = cross_term(m[4], m[8], m[5], m[7]);
    adj[1] = cross_term(m[2], m[7], m[1], m[8]);
    adj[2] = cross_term(m[1], m[5], m[2], m[4]);
    adj[3] = cross_term(m[5], m[6], m[3], m[8]);
    adj[4] = cross_term(m[0], m[8], m[2], m[6]);
    adj[5] = cross_term(m[2], m[3], m[0], m[5]);
    adj[6] = cross_term(m[3], m[7], m[4], m[6]);
    adj[7] = cross_term(m[1], m[6], m[0], m[7]);
    adj[8] = cross_term(m[0], m[4], m[1], m[3]);
    det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
    res = '0;
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    det_mag = (det < 0) ? -det : det;
    sat = 1'b0;
    for (int i = 0; i < 9; i++) begin
      neg = (adj[i] < 0) != (det < 0);
      num = (adj[i] < 0) ? -adj[i] : adj[i];
      num = num << (2 * mx3_pkg::FRAC_BITS_DEF);
      quo = num / det_mag;
      if (neg) begin
        if (quo > 128'h8000_0000) begin
          ent[i] = 32'h8000_0000;
          sat = 1'b1;
        end else begin
          ent[i] = -quo[31:0];
        end
      end else begin
        if (quo > 128'h7FFF_FFFF) begin
          ent[i] = 32'h7FFF_FFFF;
          sat = 1'b1;
        end else begin
          ent[i] = quo[31:0];
        end
      end
    end
    res.r00 = ent[0]; res.r01 = ent[1]; res.r02 = ent[2];
    res.r10 = ent[3]; res.r11 = ent[4]; res.r12 = ent[5];
    res.r20 = ent[6]; res.r21 = ent[7]; res.r22 = ent[8];
    res.saturated = sat;
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    mx3_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (inverse_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result %h", out_data);
        end else begin
          want = inverse_q.pop_front();
          if (want !== out_data) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected %h actual %h", want, out_data);
          end
        end
      end
      if (in_valid && in_ready)
        inverse_q.push_back(predict_inverse(in_data));
      pending = inverse_q.size();
    end
  end

endmodule

[tb/tb_matrix3x3_inverse.sv]
// ----------------------------------------------------------------------------
// tb_matrix3x3_inverse
// drives directed and random matrices into the inverse pipeline with random
// gaps and output stalls; the checker judges every result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_matrix3x3_inverse;

  localparam int NUM_RANDOM = 1600;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  mx3_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  mx3_pkg::out_t out_data;
  int            fail_count;
  int            pending;
  int            cycle_count;
  int            sent;

  matrix3x3_inverse DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  mx3_inverse_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic int draw_gap(int idx);
    return ((idx % 400) < 100) ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic send_matrix(mx3_pkg::in_t mat);
    int gap;
    gap = draw_gap(sent);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= mat;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  function automatic mx3_pkg::in_t make_matrix(logic [31:0] e [9]);
    mx3_pkg::in_t mat;
    mat = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return mat;
  endfunction

  function automatic logic [31:0] rand_entry(int kind);
    case (kind)
      0: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      1: return $urandom();
      default: return 32'($urandom_range(0, 510)) - 32'd255;
    endcase
  endfunction

  // receiver: random stalls, one long hold-off
  initial begin
    int stall;
    int got;
    got = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_gap(got);
      if (got == 300)
        stall = 200;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got++;
    end
  end

  initial begin
    logic [31:0] e [9];
    int kind;
    in_valid = 1'b0;
    in_data  = '0;
    sent = 0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests
    e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
    send_matrix(make_matrix(e));
    e = '{default: 0};
    send_matrix(make_matrix(e));
    e = '{default: 32'h8000_0000};
    send_matrix(make_matrix(e));
    e = '{default: 32'h7FFF_FFFF};
    send_matrix(make_matrix(e));
    e = '{32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h8000_0000};
    send_matrix(make_matrix(e));
    e = '{32'h7FFF_FFFF, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 5, 3, 32'h8000_0000, 32'hFFFF_FFFF};
    send_matrix(make_matrix(e));
    e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_matrix(make_matrix(e));
    e = '{32'hFFFF_FFFF, 0, 0, 0, 1, 0, 0, 0, 1};
    send_matrix(make_matrix(e));
    e = '{0, ONE, 0, ONE, 0, 0, 0, 0, ONE};
    send_matrix(make_matrix(e));
    e = '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE, 9 * ONE};
    send_matrix(make_matrix(e));
    e = '{2 * ONE, 0, 0, 0, -(4 * ONE), 0, 0, 0, ONE >> 1};
    send_matrix(make_matrix(e));
    e = '{ONE, 32'h7FFF_FFFF, 0, 0, ONE, 0, 0, 0, ONE};
    send_matrix(make_matrix(e));
    e = '{0, 0, 0, ONE, ONE, ONE, 3, 7, 9};
    send_matrix(make_matrix(e));
    e = '{2, 0, 0, 0, 2, 0, 0, 0, -2};
    send_matrix(make_matrix(e));
    e = '{32'h0001_8000, 32'hFFFF_0000, 32'h0000_4000, 32'h0002_0000, 32'h0000_0001,
          32'hFFFE_0000, 32'h0000_8000, 32'h0003_0000, 32'hFFFF_C000};
    send_matrix(make_matrix(e));

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 800) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++)
        e[k] = rand_entry(kind < 6 ? 0 : (kind < 8 ? 1 : 2));
      if (kind == 9) begin
        // dependent rows give a zero determinant
        e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
      end
      send_matrix(make_matrix(e));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (mx3_pkg::PIPE_LAT + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[matrix3x3_inverse.f]
+incdir+design
design/mx3_pkg.sv
design/mx3_cofactor.sv
design/mx3_det.sv
design/mx3_div_lane.sv
design/matrix3x3_inverse.sv
tb/mx3_inverse_checker.sv
tb/tb_matrix3x3_inverse.sv
